/* rtl/csl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csl_pkg
// Types, token kind codes and character helpers for the C subset lexer.
// ----------------------------------------------------------------------------
package csl_pkg;

  localparam int KW_MAX_LEN = 8;
  localparam int KW_BITS    = KW_MAX_LEN * 8;
  localparam int KW_COUNT   = 32;

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_OP1, MODE_OP2, MODE_NUM, MODE_IDENT,
    MODE_STR, MODE_CHQ, MODE_CHESC, MODE_CHEND
  } mode_t;

  localparam logic [6:0] K_ARROW    = 7'd32;
  localparam logic [6:0] K_SHL_EQ   = 7'd48;
  localparam logic [6:0] K_SHL      = 7'd49;
  localparam logic [6:0] K_SHR_EQ   = 7'd52;
  localparam logic [6:0] K_SHR      = 7'd53;
  localparam logic [6:0] K_TILDE    = 7'd41;
  localparam logic [6:0] K_NUMBER   = 7'd58;
  localparam logic [6:0] K_STRING   = 7'd59;
  localparam logic [6:0] K_CHAR     = 7'd60;
  localparam logic [6:0] K_IDENT    = 7'd61;
  localparam logic [6:0] K_COMMA    = 7'd62;
  localparam logic [6:0] K_LPAREN   = 7'd63;
  localparam logic [6:0] K_RPAREN   = 7'd64;
  localparam logic [6:0] K_LBRACK   = 7'd65;
  localparam logic [6:0] K_RBRACK   = 7'd66;
  localparam logic [6:0] K_LBRACE   = 7'd67;
  localparam logic [6:0] K_RBRACE   = 7'd68;
  localparam logic [6:0] K_SEMI     = 7'd69;
  localparam logic [6:0] K_END      = 7'd70;
  localparam logic [6:0] K_INVALID  = 7'd71;
  localparam logic [6:0] K_UNCLOSED = 7'd72;
  localparam logic [6:0] NO_PAIR    = 7'd0;
  localparam logic [6:0] TO_DOUBLE  = 7'd1;

  localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

  typedef struct packed {
    logic        last;
    logic [15:0] column_number;
    logic [15:0] line_number;
    logic [15:0] text_length;
    logic [31:0] start_offset;
    logic [30:0] value;
    logic [6:0]  kind;
  } res_t;

  typedef struct packed {
    logic [15:0] line;
    logic [15:0] col;
  } pos_t;

  // Keyword names, last character in the low byte.
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    64'("auto"), 64'("break"), 64'("case"), 64'("char"), 64'("const"),
    64'("continue"), 64'("default"), 64'("do"), 64'("double"), 64'("else"),
    64'("enum"), 64'("extern"), 64'("float"), 64'("for"), 64'("goto"),
    64'("if"), 64'("int"), 64'("long"), 64'("register"), 64'("return"),
    64'("short"), 64'("signed"), 64'("sizeof"), 64'("static"), 64'("struct"),
    64'("switch"), 64'("typedef"), 64'("union"), 64'("unsigned"), 64'("void"),
    64'("volatile"), 64'("while")
  };

  function automatic pos_t advance(pos_t p, logic [7:0] b);
    pos_t r;
    r = p;
    if (b == 8'h0A) begin
      if (p.line != 16'hFFFF) r.line = p.line + 16'd1;
      r.col = 16'd1;
    end else if (b == 8'h09) begin
      r.col = (p.col > 16'hFFFB) ? 16'hFFFF : p.col + 16'd4;
    end else if (p.col != 16'hFFFF) begin
      r.col = p.col + 16'd1;
    end
    return r;
  endfunction

  function automatic logic [6:0] op_single(logic [7:0] f);
    case (f)
      "-":     return 7'd35;
      "+":     return 7'd38;
      "!":     return 7'd40;
      "/":     return 7'd43;
      "*":     return 7'd45;
      "%":     return 7'd47;
      "<":     return 7'd51;
      ">":     return 7'd55;
      "=":     return 7'd57;
      default: return K_INVALID;
    endcase
  endfunction

  function automatic logic [6:0] op_pair(logic [7:0] f, logic [7:0] b);
    case (f)
      "-":     return (b == ">") ? K_ARROW : (b == "-") ? 7'd33 : (b == "=") ? 7'd34 : NO_PAIR;
      "+":     return (b == "+") ? 7'd36 : (b == "=") ? 7'd37 : NO_PAIR;
      "!":     return (b == "=") ? 7'd39 : NO_PAIR;
      "/":     return (b == "=") ? 7'd42 : NO_PAIR;
      "*":     return (b == "=") ? 7'd44 : NO_PAIR;
      "%":     return (b == "=") ? 7'd46 : NO_PAIR;
      "<":     return (b == "<") ? TO_DOUBLE : (b == "=") ? 7'd50 : NO_PAIR;
      ">":     return (b == ">") ? TO_DOUBLE : (b == "=") ? 7'd54 : NO_PAIR;
      "=":     return (b == "=") ? 7'd56 : NO_PAIR;
      default: return NO_PAIR;
    endcase
  endfunction

  function automatic logic [7:0] escape_code(logic [7:0] b);
    case (b)
      "a":     return 8'd7;
      "b":     return 8'd8;
      "f":     return 8'd12;
      "n":     return 8'd10;
      "r":     return 8'd13;
      "t":     return 8'd9;
      "v":     return 8'd11;
      "\\":    return 8'd92;
      default: return 8'd0;
    endcase
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_ident_start(logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) || (b == "_");
  endfunction

  function automatic logic [6:0] ident_kind(logic [KW_BITS-1:0] w, logic [15:0] cnt);
    logic [6:0] k;
    k = K_IDENT;
    if (cnt <= 16'(KW_MAX_LEN)) begin
      for (int i = KW_COUNT - 1; i >= 0; i--) begin
        if (w == KW_BITS'(KW_TEXT[i])) k = 7'(i);
      end
    end
    return k;
  endfunction

endpackage
`default_nettype wire

/* rtl/c_subset_lexer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c_subset_lexer
// Byte-serial lexer for a subset of C, one source byte per item.
// ----------------------------------------------------------------------------
// A token is registered into the four-entry result queue on the byte ending it.
// Throughput: one byte per cycle while the queue holds two entries or fewer;
// a byte that ends two tokens writes two entries, read out through one port.
// Reset: synchronous; scanner idle, position at offset 0, line 1, column 1,
// result queue empty.
module c_subset_lexer (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  input  wire  [7:0]   s_tdata,   // ch
  input  wire          s_tuser,   // end_of_input
  output logic         m_tvalid,
  input  wire          m_tready,
  output logic [119:0] m_tdata,   // kind, value, start_offset, text_length,
                                  // line_number, column_number, zero fill
  output logic         m_tlast    // last
);
  import csl_pkg::*;

  mode_t               mode, mode_next;
  logic [KW_BITS-1:0]  window, window_next;
  logic [15:0]         cnt, cnt_next;
  logic [30:0]         acc, acc_next;
  logic [7:0]          cv, cv_next;
  logic [31:0]         pos, pos_next;
  logic [31:0]         ts, ts_next;
  pos_t                lc, lc_next;

  res_t                ra, rb, q0, q1;
  logic                va, vb;
  res_t                queue [4];
  logic [1:0]          wptr, rptr;
  logic [2:0]          count;
  logic                in_fire, out_fire;

  assign in_fire  = s_tvalid && s_tready;
  assign out_fire = m_tvalid && m_tready;
  assign s_tready = (count <= 3'd2);

  always_comb begin
    logic [7:0]  b;
    pos_t        adv;
    logic        consumed;
    logic [6:0]  k;
    logic [34:0] prod;
    b = s_tdata;
    adv = advance(lc, b);
    consumed = 1'b0;
    k = NO_PAIR;
    prod = '0;
    mode_next = mode;
    window_next = window;
    cnt_next = cnt;
    acc_next = acc;
    cv_next = cv;
    pos_next = pos;
    ts_next = ts;
    lc_next = lc;
    va = 1'b0;
    vb = 1'b0;
    ra = '0;
    rb = '0;
    ra.start_offset = ts;
    ra.line_number = adv.line;
    ra.column_number = adv.col;
    if (in_fire && !s_tuser) begin
      case (mode)
        MODE_OP1: begin
          k = op_pair(cv, b);
          if (k != NO_PAIR) begin
            consumed = 1'b1;
            if (k == TO_DOUBLE) begin
              mode_next = MODE_OP2;
            end else begin
              va = 1'b1;
              ra.kind = k;
              mode_next = MODE_IDLE;
            end
          end
        end
        MODE_OP2: begin
          if (b == "=") begin
            consumed = 1'b1;
            va = 1'b1;
            ra.kind = (cv == "<") ? K_SHL_EQ : K_SHR_EQ;
            mode_next = MODE_IDLE;
          end
        end
        MODE_NUM: begin
          if (is_digit(b)) begin
            consumed = 1'b1;
            prod = {1'b0, acc, 3'b0} + {3'b0, acc, 1'b0} + {27'b0, b - 8'h30};
            acc_next = (prod > 35'(NUM_MAX)) ? NUM_MAX : prod[30:0];
          end
        end
        MODE_IDENT: begin
          if (is_ident_start(b) || is_digit(b)) begin
            consumed = 1'b1;
            if (cnt < 16'(KW_MAX_LEN)) window_next = {window[KW_BITS-9:0], b};
            if (cnt != 16'hFFFF) cnt_next = cnt + 16'd1;
          end
        end
        MODE_STR: begin
          consumed = 1'b1;
          if (b == "\"") begin
            va = 1'b1;
            ra.kind = K_STRING;
            ra.text_length = cnt;
            mode_next = MODE_IDLE;
          end else if (cnt != 16'hFFFF) begin
            cnt_next = cnt + 16'd1;
          end
        end
        MODE_CHQ: begin
          consumed = 1'b1;
          if (b == "\\") begin
            mode_next = MODE_CHESC;
          end else begin
            cv_next = b;
            mode_next = MODE_CHEND;
          end
        end
        MODE_CHESC: begin
          consumed = 1'b1;
          cv_next = escape_code(b);
          mode_next = MODE_CHEND;
        end
        MODE_CHEND: begin
          consumed = 1'b1;
          va = 1'b1;
          ra.kind = K_CHAR;
          ra.value = {23'b0, cv};
          mode_next = MODE_IDLE;
        end
        default: ;
      endcase
      if (consumed) begin
        pos_next = pos + 32'd1;
        lc_next = adv;
      end
    end
    // Flush of the pending token, as it stands, before the current position moves.
    if (in_fire && !consumed && mode != MODE_IDLE) begin
      ra = '0;
      ra.start_offset = ts;
      ra.line_number = lc.line;
      ra.column_number = lc.col;
      va = 1'b1;
      case (mode)
        MODE_OP1: ra.kind = op_single(cv);
        MODE_OP2: ra.kind = (cv == "<") ? K_SHL : K_SHR;
        MODE_NUM: begin
          ra.kind = K_NUMBER;
          ra.value = acc;
        end
        MODE_IDENT: begin
          ra.kind = ident_kind(window, cnt);
          ra.text_length = cnt;
        end
        MODE_STR: begin
          ra.kind = K_UNCLOSED;
          ra.text_length = cnt;
        end
        default: begin
          ra.kind = K_CHAR;
          ra.value = {23'b0, cv};
        end
      endcase
      mode_next = MODE_IDLE;
    end
    rb.line_number = adv.line;
    rb.column_number = adv.col;
    rb.start_offset = pos;
    if (in_fire && s_tuser) begin
      vb = 1'b1;
      rb.kind = K_END;
      rb.line_number = lc.line;
      rb.column_number = lc.col;
      ts_next = pos;
      mode_next = MODE_IDLE;
    end else if (in_fire && !consumed) begin
      ts_next = pos;
      pos_next = pos + 32'd1;
      lc_next = adv;
      if (b == " " || b == 8'h09 || b == 8'h0A || b == 8'h0D || b == 8'h0B || b == 8'h0C) begin
        vb = 1'b0;
      end else if (op_single(b) != K_INVALID) begin
        cv_next = b;
        mode_next = MODE_OP1;
      end else if (is_digit(b)) begin
        acc_next = {23'b0, b - 8'h30};
        mode_next = MODE_NUM;
      end else if (is_ident_start(b)) begin
        window_next = {{(KW_BITS-8){1'b0}}, b};
        cnt_next = 16'd1;
        mode_next = MODE_IDENT;
      end else if (b == "\"") begin
        cnt_next = 16'd0;
        mode_next = MODE_STR;
      end else if (b == "'") begin
        cv_next = 8'd0;
        mode_next = MODE_CHQ;
      end else begin
        vb = 1'b1;
        case (b)
          "~":     rb.kind = K_TILDE;
          ",":     rb.kind = K_COMMA;
          "(":     rb.kind = K_LPAREN;
          ")":     rb.kind = K_RPAREN;
          "[":     rb.kind = K_LBRACK;
          "]":     rb.kind = K_RBRACK;
          "{":     rb.kind = K_LBRACE;
          "}":     rb.kind = K_RBRACE;
          ";":     rb.kind = K_SEMI;
          default: begin
            rb.kind = K_INVALID;
            rb.value = {23'b0, b};
          end
        endcase
      end
    end
    q0 = va ? ra : rb;
    q1 = rb;
    if (va && vb) q1.last = 1'b1;
    else q0.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      window <= '0;
      cnt <= '0;
      acc <= '0;
      cv <= '0;
      pos <= '0;
      ts <= '0;
      lc <= '{line: 16'd1, col: 16'd1};
    end else begin
      mode <= mode_next;
      window <= window_next;
      cnt <= cnt_next;
      acc <= acc_next;
      cv <= cv_next;
      pos <= pos_next;
      ts <= ts_next;
      lc <= lc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (va || vb) queue[wptr] <= q0;
    if (va && vb) queue[wptr + 2'd1] <= q1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      wptr <= wptr + 2'(va) + 2'(vb);
      rptr <= rptr + 2'(out_fire);
      count <= count + 3'(va) + 3'(vb) - 3'(out_fire);
    end
  end

  assign m_tvalid = (count != 3'd0);
  assign m_tdata  = {2'b0, queue[rptr].column_number, queue[rptr].line_number,
                     queue[rptr].text_length, queue[rptr].start_offset,
                     queue[rptr].value, queue[rptr].kind};
  assign m_tlast  = queue[rptr].last;

endmodule
`default_nettype wire
